### src/sld_pkg.sv
// Shared types, constants and text tables for the serial LED dimmer.
// No dependencies; imported by every module of the block.
package sld_pkg;

    localparam int LINE_CHARS_DEF = 20;
    localparam int TEXT_KEEP      = 6;      // only the first six line chars matter
    localparam logic [2:0] EFF_MAX = 3'd7;  // text length saturates here

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [23:0] CMD_NED = "ned";
    localparam logic [23:0] CMD_OPP = "opp";
    localparam logic [31:0] CMD_LYS = "lys=";

    localparam logic [7:0] STEP_SIZE_RST  = 8'd6;
    localparam logic [5:0] MAX_LEVEL_RST  = 6'd32;
    localparam logic [7:0] FULL_DUTY_RST  = 8'd200;
    localparam logic [7:0] PWM_PERIOD_RST = 8'd200;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_DOWN,
        OP_UP,
        OP_TICK
    } op_t;

    typedef enum logic [1:0] {
        CFG_STEP_SIZE,
        CFG_MAX_LEVEL,
        CFG_FULL_DUTY,
        CFG_PWM_PERIOD
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MSG_NONE,
        MSG_RETRY,
        MSG_NONUM,
        MSG_MANY
    } msg_t;

    typedef enum logic [1:0] {
        LOP_HOLD,
        LOP_DOWN,
        LOP_UP,
        LOP_SET
    } lvl_op_t;

    typedef struct packed {
        logic       act;
        logic       tick;
        lvl_op_t    op;
        logic [6:0] set_val;
    } dim_cmd_t;

    typedef struct packed {
        logic       is_ned;
        logic       is_opp;
        logic       lys;
        logic       too_long;
        logic       has_digit;
        logic [6:0] value;
    } line_eval_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       crlf;
        msg_t       msg;
    } desc_t;

    localparam int RETRY_LEN = 12;
    localparam int NONUM_LEN = 29;
    localparam int MANY_LEN  = 33;

    localparam logic [8*RETRY_LEN-1:0] RETRY_TXT =
        {"Prov igjen", CHAR_CR, CHAR_LF};
    localparam logic [8*NONUM_LEN-1:0] NONUM_TXT =
        {"Du tastet ikke inn et tall!", CHAR_CR, CHAR_LF};
    localparam logic [8*MANY_LEN-1:0] MANY_TXT =
        {"Du tastet inn for mange siffer!", CHAR_CR, CHAR_LF};

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [5:0] msg_len(msg_t m);
        logic [5:0] n;
        unique case (m)
            MSG_NONE:  n = 6'd0;
            MSG_RETRY: n = 6'(RETRY_LEN);
            MSG_NONUM: n = 6'(NONUM_LEN);
            MSG_MANY:  n = 6'(MANY_LEN);
            default:   n = 6'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] msg_char(msg_t m, logic [5:0] idx);
        logic [7:0] ch;
        ch = CHAR_NUL;
        unique case (m)
            MSG_NONE:  ch = CHAR_NUL;
            MSG_RETRY: if (int'(idx) < RETRY_LEN)
                ch = RETRY_TXT[8*(RETRY_LEN-1-int'(idx)) +: 8];
            MSG_NONUM: if (int'(idx) < NONUM_LEN)
                ch = NONUM_TXT[8*(NONUM_LEN-1-int'(idx)) +: 8];
            MSG_MANY:  if (int'(idx) < MANY_LEN)
                ch = MANY_TXT[8*(MANY_LEN-1-int'(idx)) +: 8];
            default:   ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

### src/serial_command_led_dimmer_unit.sv
// Top level of the serial command LED dimmer.
// Depends on sld_pkg, sld_line, sld_dimmer and sld_emit.
//
// Input channel (in_valid/in_ready): a request is a received byte, a down or
// up button press, or a PWM tick, selected by operation. Output channel
// (out_valid/out_ready): one result per cycle while out_ready holds, either a
// char to transmit (kind 0) or a port byte (kind 1); last marks the final result
// of a request. A byte gives 1 result (its echo); a carriage return gives 3, 15,
// 32 or 36 (echo, CR LF, reply text). A tick gives 1 result, a button press none.
// All state updates at the edge that accepts the request. The first result goes
// through the held response register, then the output register; the rest follow
// one per cycle while out_ready holds, paced by the single output register. The
// next request is taken in the cycle its predecessor's final result enters the
// output register, so unstalled single-result requests stream at one per cycle.
// A receiver stall holds the output register and, behind it, the input.
// Config writes (cfg_we/cfg_index/cfg_data) take effect at once and belong to
// idle periods. Reset clears the line, level, counter and pending results and
// loads the register defaults; no clearing pass is needed.
module serial_command_led_dimmer_unit import sld_pkg::*; #(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] rx_byte,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] tx_char,
    output logic [7:0] port_value,
    output logic       last
);

    logic [7:0] step_size_reg;
    logic [5:0] max_level_reg;
    logic [7:0] full_duty_reg;
    logic [7:0] pwm_period_reg;

    op_t        op;
    logic       acc;
    logic       is_cr;
    logic       line_store, line_clear;
    line_eval_t line_eval;
    dim_cmd_t   dim_cmd;
    logic [7:0] dim_port;
    logic [5:0] dim_level;
    desc_t      desc;
    logic       push;
    logic       take_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= STEP_SIZE_RST;
            max_level_reg  <= MAX_LEVEL_RST;
            full_duty_reg  <= FULL_DUTY_RST;
            pwm_period_reg <= PWM_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STEP_SIZE:  step_size_reg  <= cfg_data;
                CFG_MAX_LEVEL:  max_level_reg  <= cfg_data[5:0];
                CFG_FULL_DUTY:  full_duty_reg  <= cfg_data;
                CFG_PWM_PERIOD: pwm_period_reg <= cfg_data;
                default:        step_size_reg  <= step_size_reg;
            endcase
        end
    end

    assign in_ready = take_ready;

    always_comb
    begin
        op         = op_t'(operation);
        acc        = in_valid && in_ready;
        is_cr      = rx_byte == CHAR_CR;
        line_store = acc && (op == OP_BYTE) && !is_cr;
        line_clear = acc && (op == OP_BYTE) && is_cr;

        dim_cmd.act     = acc;
        dim_cmd.tick    = acc && (op == OP_TICK);
        dim_cmd.op      = LOP_HOLD;
        dim_cmd.set_val = line_eval.value;
        unique case (op)
            OP_BYTE:
            begin
                if (is_cr)
                begin
                    priority if (line_eval.is_ned)
                        dim_cmd.op = LOP_DOWN;
                    else if (line_eval.is_opp)
                        dim_cmd.op = LOP_UP;
                    else if (line_eval.lys && !line_eval.too_long && line_eval.has_digit)
                        dim_cmd.op = LOP_SET;
                    else
                        dim_cmd.op = LOP_HOLD;
                end
            end
            OP_DOWN: dim_cmd.op = LOP_DOWN;
            OP_UP:   dim_cmd.op = LOP_UP;
            OP_TICK: dim_cmd.op = LOP_HOLD;
            default: dim_cmd.op = LOP_HOLD;
        endcase

        desc.kind = op == OP_TICK;
        desc.data = desc.kind ? dim_port : rx_byte;
        desc.crlf = (op == OP_BYTE) && is_cr;
        desc.msg  = MSG_NONE;
        if (desc.crlf)
        begin
            // step commands lack the set prefix and are answered as retries too
            if (!line_eval.lys)
                desc.msg = MSG_RETRY;
            else if (line_eval.too_long)
                desc.msg = MSG_MANY;
            else if (!line_eval.has_digit)
                desc.msg = MSG_NONUM;
        end
        push = acc && ((op == OP_BYTE) || (op == OP_TICK));
    end

    sld_line #(
        .LINE_CHARS(LINE_CHARS)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .store   (line_store),
        .clear   (line_clear),
        .rx_byte (rx_byte),
        .eval    (line_eval)
    );

    sld_dimmer u_dimmer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dim_cmd),
        .step_size  (step_size_reg),
        .max_level  (max_level_reg),
        .full_duty  (full_duty_reg),
        .pwm_period (pwm_period_reg),
        .port_value (dim_port),
        .level      (dim_level)
    );

    sld_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .desc       (desc),
        .take_ready (take_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .tx_char    (tx_char),
        .port_value (port_value),
        .last       (last)
    );

    // level stays within the limit that was in force when the request came in
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (dim_level <= $past(max_level_reg)))
        else $error("level above max_level after request");

    // a port update is always the only result of its tick
    a_port_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> last)
        else $error("port update not marked last");

    a_port_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> (tx_char == 8'd0))
        else $error("port update carries a transmit char");

    // a request that yields results is only taken once the sequencer is free
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> take_ready)
        else $error("request pushed while sequencer busy");

endmodule

### src/sld_line.sv
// Line buffer: collects received chars and decodes the finished line.
// Depends on sld_pkg.
module sld_line import sld_pkg::*; #(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       store,
    input  logic       clear,
    input  logic [7:0] rx_byte,
    output line_eval_t eval
);

    localparam int LEN_W = $clog2(LINE_CHARS + 1);

    logic [7:0]       text_reg [TEXT_KEEP];
    logic [2:0]       eff_reg, eff_next;
    logic             zero_reg, zero_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             wr_en;
    logic             room;
    logic             d4, d5;
    logic [3:0]       v4, v5;

    // Text length ends at the first NUL; later chars never count.
    always_comb
    begin
        eff_next  = eff_reg;
        zero_next = zero_reg;
        len_next  = len_reg;
        wr_en     = 1'b0;
        room      = len_reg < LEN_W'(LINE_CHARS);
        if (clear)
        begin
            eff_next  = '0;
            zero_next = 1'b0;
            len_next  = '0;
        end
        else if (store && room)
        begin
            len_next = len_reg + LEN_W'(1);
            if (!zero_reg)
            begin
                if (rx_byte == CHAR_NUL)
                begin
                    zero_next = 1'b1;
                end
                else
                begin
                    wr_en = eff_reg < 3'(TEXT_KEEP);
                    if (eff_reg != EFF_MAX)
                    begin
                        eff_next = eff_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg  <= '0;
            zero_reg <= 1'b0;
            len_reg  <= '0;
        end
        else
        begin
            eff_reg  <= eff_next;
            zero_reg <= zero_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_reg[eff_reg] <= rx_byte;
        end
    end

    always_comb
    begin
        d4 = (eff_reg >= 3'd5) && is_digit(text_reg[4]);
        d5 = (eff_reg >= 3'd6) && is_digit(text_reg[5]);
        v4 = text_reg[4][3:0];
        v5 = text_reg[5][3:0];
        eval.is_ned = (eff_reg == 3'd3)
            && ({text_reg[0], text_reg[1], text_reg[2]} == CMD_NED);
        eval.is_opp = (eff_reg == 3'd3)
            && ({text_reg[0], text_reg[1], text_reg[2]} == CMD_OPP);
        eval.lys = (eff_reg >= 3'd4)
            && ({text_reg[0], text_reg[1], text_reg[2], text_reg[3]} == CMD_LYS);
        eval.too_long  = eff_reg == EFF_MAX;
        eval.has_digit = d4 || d5;
        // first digit run of at most two chars
        if (d4 && d5)
        begin
            eval.value = 7'({v4, 3'b000}) + 7'({v4, 1'b0}) + 7'(v5);
        end
        else if (d4)
        begin
            eval.value = 7'(v4);
        end
        else
        begin
            eval.value = 7'(v5);
        end
    end

endmodule

### src/sld_dimmer.sv
// Brightness level and PWM counter, with the port byte for a tick.
// Depends on sld_pkg.
module sld_dimmer import sld_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dim_cmd_t   cmd,
    input  logic [7:0] step_size,
    input  logic [5:0] max_level,
    input  logic [7:0] full_duty,
    input  logic [7:0] pwm_period,
    output logic [7:0] port_value,
    output logic [5:0] level
);

    logic [5:0]  level_reg, level_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [5:0]  lvl_sat;
    logic [6:0]  lvl_inc;
    logic [7:0]  cnt_inc;
    logic [13:0] duty_prod;
    logic        at_full;
    logic        on_phase;

    always_comb
    begin
        // a lowered max_level takes hold at the next request
        lvl_sat = (level_reg >= max_level) ? max_level : level_reg;
        lvl_inc = 7'(lvl_sat) + 7'd1;
        unique case (cmd.op)
            LOP_HOLD: level_next = lvl_sat;
            LOP_DOWN: level_next = (lvl_sat != 6'd0) ? lvl_sat - 6'd1 : lvl_sat;
            LOP_UP:   level_next = (lvl_inc >= 7'(max_level)) ? max_level : lvl_inc[5:0];
            LOP_SET:  level_next = (cmd.set_val >= 7'(max_level))
                                   ? max_level : cmd.set_val[5:0];
            default:  level_next = lvl_sat;
        endcase
    end

    always_comb
    begin
        cnt_inc   = cnt_reg + 8'd1;
        duty_prod = 14'(lvl_sat) * 14'(step_size);
        at_full   = lvl_sat >= max_level;
        if (at_full)
        begin
            on_phase = cnt_inc <= full_duty;
        end
        else
        begin
            on_phase = 14'(cnt_inc) <= duty_prod;
        end
        port_value = {1'b1, ~lvl_sat, ~on_phase};
        cnt_next   = (cnt_inc == pwm_period) ? 8'd0 : cnt_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.act)
            begin
                level_reg <= level_next;
            end
            if (cmd.tick)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    assign level = level_reg;

endmodule

### src/sld_emit.sv
// Result sequencer: holds one response and plays its chars into the output register.
// Depends on sld_pkg.
module sld_emit import sld_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  desc_t      desc,
    output logic       take_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] tx_char,
    output logic [7:0] port_value,
    output logic       last
);

    logic       cur_valid_reg;
    desc_t      cur_reg;
    logic [5:0] pos_reg;
    logic       out_valid_reg;
    logic       kind_reg, last_reg;
    logic [7:0] tx_reg, port_reg;

    logic [5:0] len;
    logic       advance;
    logic       at_last;
    logic       cur_done;
    logic [7:0] ch;

    always_comb
    begin
        len      = 6'd1 + (cur_reg.crlf ? 6'd2 : 6'd0) + msg_len(cur_reg.msg);
        advance  = cur_valid_reg && (!out_valid_reg || out_ready);
        at_last  = pos_reg == (len - 6'd1);
        cur_done = advance && at_last;
        take_ready = !cur_valid_reg || cur_done;
        // echo or port byte, then CR LF, then reply text
        if (pos_reg == 6'd0)
        begin
            ch = cur_reg.data;
        end
        else if (pos_reg == 6'd1)
        begin
            ch = CHAR_CR;
        end
        else if (pos_reg == 6'd2)
        begin
            ch = CHAR_LF;
        end
        else
        begin
            ch = msg_char(cur_reg.msg, pos_reg - 6'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (cur_done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                pos_reg <= pos_reg + 6'd1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cur_reg <= desc;
        end
        if (advance)
        begin
            kind_reg <= cur_reg.kind;
            tx_reg   <= cur_reg.kind ? 8'd0 : ch;
            port_reg <= cur_reg.kind ? cur_reg.data : 8'd0;
            last_reg <= at_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign tx_char    = tx_reg;
    assign port_value = port_reg;
    assign last       = last_reg;

endmodule
